/* design/bidsmm_pkg.sv */
// ----------------------------------------------------------------------------
// bidsmm_pkg
// Shared types and constants for the bitmap id set with minimum and maximum.
// ----------------------------------------------------------------------------
`default_nettype none

package bidsmm_pkg;

  // id space and field widths
  localparam int ID_SPACE = 1024;
  localparam int ID_W     = 10;
  localparam int COUNT_W  = 11;
  localparam int ACT_W    = 2;

  // bitmap storage: 32-bit words
  localparam int WORD_W = 32;
  localparam int BPOS_W = $clog2(WORD_W);
  localparam int WORDS  = (ID_SPACE + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 40;
  localparam int M_USED_W  = 1 + COUNT_W + ID_W + ID_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

endpackage

`default_nettype wire

/* design/bitmap_id_set_min_max.sv */
// ----------------------------------------------------------------------------
// bitmap_id_set_min_max
// Id set held as a bitmap in RAM, with member count, minimum and maximum.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tuser: action; tdata: elem_id
//  m_axis   | out | tdata: hit, member_count, min_member, max_member, is_empty
//
//  An item runs through ST_IDLE, ST_MOD and ST_DONE; clear and out-of-range
//  ids skip ST_MOD. When the removed id was the minimum or maximum, ST_SCAN
//  reads further bitmap words one at a time through the single read port of
//  the bitmap RAM, up to WORDS-1 of them. Reset clears the per-word valid
//  bits, so no clearing pass is needed. One item is in work at a time; a
//  result waiting in the output register does not stop the next transfer in.
//
`default_nettype none

module bitmap_id_set_min_max
  import bidsmm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [9:0] elem_id
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] action
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] hit, [11:1] member_count, [21:12] min_member, [31:22] max_member,
  // [32] is_empty
  output logic      [M_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  function automatic logic [BPOS_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BPOS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = BPOS_W'(i);
    end
    return pos;
  endfunction

  function automatic logic [BPOS_W-1:0] highest_set(input logic [WORD_W-1:0] w);
    logic [BPOS_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) pos = BPOS_W'(i);
    end
    return pos;
  endfunction

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic                 hit_q, hit_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [ID_W-1:0]      min_q, min_d;
  logic [ID_W-1:0]      max_q, max_d;
  logic [WIDX_W-1:0]    scan_idx_q, scan_idx_d;
  logic                 scan_up_q, scan_up_d;
  logic [WORDS-1:0]     vld_q, vld_d;
  logic                 rd_vld_q;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WIDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  action_e              in_act;
  logic [ID_W-1:0]      in_id;
  logic                 in_space;
  logic [WIDX_W-1:0]    widx;
  logic [BPOS_W-1:0]    bpos;
  logic [WORD_W-1:0]    bmask;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    word_clr;
  logic [WORD_W-1:0]    above;
  logic [WORD_W-1:0]    below;
  logic                 present;
  logic                 out_free;
  logic                 empty;

  assign in_act   = action_e'(s_axis_tuser[ACT_W-1:0]);
  assign in_id    = s_axis_tdata[ID_W-1:0];
  assign in_space = 32'(in_id) < ID_SPACE;

  assign widx     = id_q[BPOS_W +: WIDX_W];
  assign bpos     = id_q[BPOS_W-1:0];
  assign bmask    = WORD_W'(1) << bpos;
  // a word never written since the last clear reads as zero
  assign word     = ram_rdata & {WORD_W{rd_vld_q}};
  assign present  = word[bpos];
  assign word_clr = word & ~bmask;
  assign above    = word_clr & ~((WORD_W'(2) << bpos) - WORD_W'(1));
  assign below    = word_clr & (bmask - WORD_W'(1));

  assign out_free = !m_valid_q || m_axis_tready;
  assign empty    = (count_q == '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    id_d       = id_q;
    hit_d      = hit_q;
    count_d    = count_q;
    min_d      = min_q;
    max_d      = max_q;
    scan_idx_d = scan_idx_q;
    scan_up_d  = scan_up_q;
    vld_d      = vld_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    ram_we     = 1'b0;
    ram_waddr  = widx;
    ram_wdata  = word;
    ram_raddr  = in_id[BPOS_W +: WIDX_W];

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d = in_act;
          id_d  = in_id;
          hit_d = 1'b0;
          if (in_act == ACT_CLEAR) begin
            vld_d   = '0;
            count_d = '0;
            min_d   = '0;
            max_d   = '0;
            state_d = ST_DONE;
          end else if (!in_space) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        state_d = ST_DONE;
        unique case (act_q)
          ACT_ADD: begin
            if (!present) begin
              ram_we      = 1'b1;
              ram_wdata   = word | bmask;
              vld_d[widx] = 1'b1;
              count_d     = count_q + COUNT_W'(1);
              hit_d       = 1'b1;
              if (empty) begin
                min_d = id_q;
                max_d = id_q;
              end else begin
                if (id_q < min_q) min_d = id_q;
                if (id_q > max_q) max_d = id_q;
              end
            end
          end
          ACT_REMOVE: begin
            if (present) begin
              ram_we    = 1'b1;
              ram_wdata = word_clr;
              count_d   = count_q - COUNT_W'(1);
              hit_d     = 1'b1;
              priority if (count_q == COUNT_W'(1)) begin
                min_d = '0;
                max_d = '0;
              end else if (id_q == min_q) begin
                if (|above) begin
                  min_d = ID_W'({widx, lowest_set(above)});
                end else begin
                  scan_idx_d = widx + WIDX_W'(1);
                  ram_raddr  = widx + WIDX_W'(1);
                  scan_up_d  = 1'b1;
                  state_d    = ST_SCAN;
                end
              end else if (id_q == max_q) begin
                if (|below) begin
                  max_d = ID_W'({widx, highest_set(below)});
                end else begin
                  scan_idx_d = widx - WIDX_W'(1);
                  ram_raddr  = widx - WIDX_W'(1);
                  scan_up_d  = 1'b0;
                  state_d    = ST_SCAN;
                end
              end else begin
                state_d = ST_DONE;
              end
            end
          end
          ACT_TEST: begin
            hit_d = present;
          end
          ACT_CLEAR: begin
            hit_d = 1'b0;
          end
          default: begin
            hit_d = 1'b0;
          end
        endcase
      end

      ST_SCAN: begin
        // another member exists, so the walk ends on a non-zero word
        if (|word) begin
          if (scan_up_q) begin
            min_d = ID_W'({scan_idx_q, lowest_set(word)});
          end else begin
            max_d = ID_W'({scan_idx_q, highest_set(word)});
          end
          state_d = ST_DONE;
        end else if (scan_up_q) begin
          scan_idx_d = scan_idx_q + WIDX_W'(1);
          ram_raddr  = scan_idx_q + WIDX_W'(1);
        end else begin
          scan_idx_d = scan_idx_q - WIDX_W'(1);
          ram_raddr  = scan_idx_q - WIDX_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({empty,
                                  empty ? {ID_W{1'b0}} : max_q,
                                  empty ? {ID_W{1'b0}} : min_q,
                                  count_q,
                                  hit_q});
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      min_q     <= '0;
      max_q     <= '0;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      min_q     <= min_d;
      max_q     <= max_d;
      vld_q     <= vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    hit_q      <= hit_d;
    scan_idx_q <= scan_idx_d;
    scan_up_q  <= scan_up_d;
    rd_vld_q   <= vld_q[ram_raddr];
    m_data_q   <= m_data_d;
  end

  bidsmm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* design/bidsmm_ram.sv */
// ----------------------------------------------------------------------------
// bidsmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bidsmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
